/* hw/rtl/mtfl_pkg.sv */
// Package for the move-to-front search list: widths, codes and shared structs.
`timescale 1ns / 1ps

package mtfl_pkg;

  localparam int unsigned DATA_W       = 32;
  localparam int unsigned STATUS_W     = 3;
  localparam int unsigned CAPACITY_DEF = 16;

  // Request kinds
  localparam logic REQ_APPEND = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_APPENDED = 3'd0,
    ST_FULL     = 3'd1,
    ST_FOUND    = 3'd2,
    ST_MISS     = 3'd3,
    ST_ZERO     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT
  } state_e;

  // Broadcast from the controller to every cell
  typedef struct packed {
    logic              append;
    logic              start;
    logic              shift;
    logic              clear;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] wdata;
  } cmd_t;

  // Report from one cell while the probe sits on it
  typedef struct packed {
    logic hit;
    logic miss;
  } cell_stat_t;

endpackage

/* hw/rtl/mtfl_cell.sv */
// One list cell: holds an entry, compares it with the probe and shifts on move-to-front.
`timescale 1ns / 1ps

module mtfl_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mtfl_pkg::cmd_t                cmd_i,
  input  logic [mtfl_pkg::DATA_W-1:0]   prev_entry_i,
  input  logic                          prev_valid_i,
  input  logic                          probe_i,
  output logic                          probe_o,
  output logic [mtfl_pkg::DATA_W-1:0]   entry_o,
  output logic                          valid_o,
  output mtfl_pkg::cell_stat_t          stat_o
);

  logic [mtfl_pkg::DATA_W-1:0] entry_q, entry_d;
  logic valid_q, valid_d;
  logic probe_q;
  logic mark_q, mark_d;
  logic match;
  logic take_append;

  // Compare the stored entry with the search key
  assign match   = valid_q && (entry_q == cmd_i.key);
  assign probe_o = probe_q && valid_q && !match;

  assign stat_o.hit  = probe_q && match;
  assign stat_o.miss = probe_q && !valid_q;

  // Append lands in the first empty cell
  assign take_append = cmd_i.append && prev_valid_i && !valid_q;

  always_comb begin
    valid_d = valid_q | take_append;
    entry_d = entry_q;
    if (take_append) begin
      entry_d = cmd_i.wdata;
    end else if (cmd_i.shift && mark_q) begin
      entry_d = prev_entry_i;
    end
  end

  // Mark every cell the probe has passed; drop marks after shift or miss
  always_comb begin
    if (cmd_i.shift || cmd_i.clear) begin
      mark_d = 1'b0;
    end else begin
      mark_d = mark_q | probe_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      probe_q <= 1'b0;
      mark_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      probe_q <= probe_i;
      mark_q  <= mark_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign valid_o = valid_q;

endmodule

/* hw/rtl/mtfl_ctrl.sv */
// Controller: request handshake, search sequencing and the result register.
`timescale 1ns / 1ps

module mtfl_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          req_type_i,
  input  logic [mtfl_pkg::DATA_W-1:0]   value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mtfl_pkg::STATUS_W-1:0] status_o,
  input  logic                          full_i,
  input  logic                          hit_i,
  input  logic                          miss_i,
  output mtfl_pkg::cmd_t                cmd_o
);

  mtfl_pkg::state_e state_q, state_d;
  mtfl_pkg::status_e status_q, status_d;
  logic out_valid_q, out_valid_d;
  logic out_load;
  logic [mtfl_pkg::DATA_W-1:0] key_q;
  logic accept;
  logic is_zero;

  assign in_ready_o = (state_q == mtfl_pkg::S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign is_zero    = (value_i == '0);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mtfl_pkg::S_IDLE: begin
        if (accept && !is_zero && req_type_i == mtfl_pkg::REQ_SEARCH) begin
          state_d = mtfl_pkg::S_SCAN;
        end
      end
      mtfl_pkg::S_SCAN: begin
        if (hit_i) begin
          state_d = mtfl_pkg::S_SHIFT;
        end else if (miss_i) begin
          state_d = mtfl_pkg::S_IDLE;
        end
      end
      mtfl_pkg::S_SHIFT: begin
        state_d = mtfl_pkg::S_IDLE;
      end
      default: begin
        state_d = mtfl_pkg::S_IDLE;
      end
    endcase
  end

  // Outputs: cell commands and result load
  always_comb begin
    cmd_o.append = 1'b0;
    cmd_o.start  = 1'b0;
    cmd_o.shift  = 1'b0;
    cmd_o.clear  = 1'b0;
    cmd_o.key    = key_q;
    cmd_o.wdata  = value_i;
    out_load     = 1'b0;
    status_d     = status_q;
    case (state_q)
      mtfl_pkg::S_IDLE: begin
        if (accept) begin
          if (is_zero) begin
            out_load = 1'b1;
            status_d = mtfl_pkg::ST_ZERO;
          end else if (req_type_i == mtfl_pkg::REQ_APPEND) begin
            out_load     = 1'b1;
            cmd_o.append = !full_i;
            status_d     = full_i ? mtfl_pkg::ST_FULL : mtfl_pkg::ST_APPENDED;
          end else begin
            cmd_o.start = 1'b1;
          end
        end
      end
      mtfl_pkg::S_SCAN: begin
        if (!hit_i && miss_i) begin
          cmd_o.clear = 1'b1;
          out_load    = 1'b1;
          status_d    = mtfl_pkg::ST_MISS;
        end
      end
      mtfl_pkg::S_SHIFT: begin
        cmd_o.shift = 1'b1;
        out_load    = 1'b1;
        status_d    = mtfl_pkg::ST_FOUND;
      end
      default: begin
        cmd_o.clear = 1'b1;
      end
    endcase
  end

  // Hold the result until the transaction completes
  assign out_valid_d = out_load || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mtfl_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      status_q <= status_d;
    end
    if (cmd_o.start) begin
      key_q <= value_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;

endmodule

/* hw/rtl/move_to_front_search_list_top.sv */
// Top level of the move-to-front search list: controller and the row of cells.
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY nonzero 32-bit values held in a row of cells, head in
// cell 0. An append or a zero value is handled in the cycle it is taken, and its status
// is ready the next cycle. A search sends a probe down the row one cell per cycle; a
// match at position h goes through the accept cycle and the probe steps up to cell h,
// then the S_SHIFT state, in which cells 0..h shift back by one and the key lands in
// cell 0. A miss ends once the probe walk reaches the first empty cell, or, on a full
// list, once the probe leaves the tail cell. One result per request; a finished result
// waits in an output register, and the next request is taken only once that register
// is empty or being read in the same cycle.
module move_to_front_search_list_top #(
  parameter int unsigned CAPACITY = mtfl_pkg::CAPACITY_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          req_type_i,
  input  logic [mtfl_pkg::DATA_W-1:0]   value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mtfl_pkg::STATUS_W-1:0] status_o
);

  mtfl_pkg::cmd_t cmd;
  logic [mtfl_pkg::DATA_W-1:0] entry   [CAPACITY];
  logic [CAPACITY-1:0]         valid;
  logic [CAPACITY-1:0]         probe;
  logic [CAPACITY-1:0]         hit_vec;
  logic [CAPACITY-1:0]         miss_vec;
  mtfl_pkg::cell_stat_t        stat    [CAPACITY];
  logic hit_any, miss_any;

  mtfl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .full_i      (valid[CAPACITY-1]),
    .hit_i       (hit_any),
    .miss_i      (miss_any),
    .cmd_o       (cmd)
  );

  // Chain the cells: cell 0 takes the key and the start pulse from the controller
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [mtfl_pkg::DATA_W-1:0] prev_entry;
    logic                        prev_valid;
    logic                        probe_in;

    if (i == 0) begin : g_head
      assign prev_entry = cmd.key;
      assign prev_valid = 1'b1;
      assign probe_in   = cmd.start;
    end else begin : g_body
      assign prev_entry = entry[i-1];
      assign prev_valid = valid[i-1];
      assign probe_in   = probe[i-1];
    end

    mtfl_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .prev_entry_i (prev_entry),
      .prev_valid_i (prev_valid),
      .probe_i      (probe_in),
      .probe_o      (probe[i]),
      .entry_o      (entry[i]),
      .valid_o      (valid[i]),
      .stat_o       (stat[i])
    );

    assign hit_vec[i]  = stat[i].hit;
    assign miss_vec[i] = stat[i].miss;
  end

  // A probe that walks off the tail is a miss too
  assign hit_any  = |hit_vec;
  assign miss_any = (|miss_vec) || probe[CAPACITY-1];

  // At most one probe is in flight
  a_probe_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hit_vec | miss_vec))
    else $error("more than one cell holds the probe");

  // A probe cannot both hit and miss
  a_hit_miss_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(hit_any && miss_any))
    else $error("hit and miss reported together");

  // No request is taken while a search is in progress
  a_busy_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (|(hit_vec | miss_vec)) |-> !in_ready_o)
    else $error("request taken during a search");

  // Occupied cells form a contiguous run from the head
  a_occ_contig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid & (valid + CAPACITY'(1))) == '0)
    else $error("occupied cells not contiguous from the head");

  // A new search starts only once the result register is free
  a_start_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start |=> !out_valid_o)
    else $error("search started with a result still pending");

endmodule
